### hdl/l2n_pkg.sv
// Package for the L2 vector normaliser: shared widths, status codes and helpers.
// Used by l2n_root_unit and vector_l2_normalizer_core; depends on nothing.
package l2n_pkg;

  localparam int MAX_DIM_DEF = 64;
  localparam int VAL_W       = 16;
  localparam int FRAC_SHIFT  = 30;
  localparam int STATUS_W    = 2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DROP = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } root_stat_t;

  // Magnitude of a signed 16-bit element; -32768 gives 32768, which still fits.
  function automatic logic [VAL_W-1:0] magnitude(input logic [VAL_W-1:0] v);
    magnitude = v[VAL_W-1] ? (~v + VAL_W'(1)) : v;
  endfunction

  // Saturates the root to 32767 and applies the sign of the element.
  function automatic logic [VAL_W-1:0] format_q(input logic [VAL_W-1:0] q,
                                                input logic           neg);
    logic [VAL_W-1:0] sat;
    sat      = q[VAL_W-1] ? {1'b0, {(VAL_W-1){1'b1}}} : q;
    format_q = neg ? (~sat + VAL_W'(1)) : sat;
  endfunction

endpackage

### hdl/l2n_store.sv
// Element buffer of the L2 vector normaliser: one write port, one registered read port.
// Depends on nothing.
module l2n_store #(
  parameter  int DEPTH  = 64,
  parameter  int DATA_W = 16,
  localparam int AW     = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/l2n_root_unit.sv
// Shared iterative unit: finds the largest q with q*q*S <= m*m*2^30, one bit a cycle.
// Depends on l2n_pkg.
module l2n_root_unit #(
  parameter int SUM_W = 37
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [l2n_pkg::VAL_W-1:0]      mag,
  input  logic [SUM_W-1:0]               sum,
  output logic [l2n_pkg::VAL_W-1:0]      q,
  output l2n_pkg::root_stat_t            stat
);

  localparam int RW = SUM_W + 32;

  // rem holds m*m*2^30 - r*r*S; acc_u is r*S*2^(i+1) and acc_v is S*2^(2i) for bit i.
  logic [RW-1:0]                 rem;
  logic [RW-1:0]                 acc_u;
  logic [RW-1:0]                 acc_v;
  logic [l2n_pkg::VAL_W-1:0]     root;
  logic [l2n_pkg::VAL_W-1:0]     bitm;
  logic                          busy;
  logic                          done;
  logic [2*l2n_pkg::VAL_W-1:0]   sq;
  logic [RW-1:0]                 delta;
  logic                          fit;

  assign sq    = mag * mag;
  assign delta = acc_u + acc_v;
  assign fit   = (delta <= rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy & bitm[0];
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitm[0]) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= RW'(sq) << l2n_pkg::FRAC_SHIFT;
      acc_u <= '0;
      acc_v <= RW'(sum) << l2n_pkg::FRAC_SHIFT;
      root  <= '0;
      bitm  <= {1'b1, {(l2n_pkg::VAL_W-1){1'b0}}};
    end else if (busy) begin
      if (fit) begin
        rem   <= rem - delta;
        root  <= root | bitm;
        acc_u <= (acc_u >> 1) + acc_v;
      end else begin
        acc_u <= acc_u >> 1;
      end
      acc_v <= acc_v >> 2;
      bitm  <= bitm >> 1;
    end
  end

  assign q         = root;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

### hdl/vector_l2_normalizer_core.sv
// After the beat carrying last: S_ADDW, S_READ, S_LOAD (root unit started unless the vector is zero),
// S_WAIT (skipped for a zero vector), S_FMT, then S_OUT; each further result repeats from S_READ.
// Throughput: elements are taken one per cycle while a vector is collected; results then leave one at
// a time, set by the 16-step shared root unit. No element is taken while results are being produced.
// Reset (rst, synchronous, active high) clears the sequencer, sum, count and drop flag;
// the element buffer is not cleared.
module vector_l2_normalizer_core #(
  parameter int MAX_DIM = l2n_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [l2n_pkg::VAL_W-1:0]       value,
  input  logic                            last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [l2n_pkg::VAL_W-1:0]       norm_value,
  output logic                            end_of_vector,
  output logic [l2n_pkg::STATUS_W-1:0]    status
);

  localparam int CW = $clog2(MAX_DIM + 1);
  localparam int AW = $clog2(MAX_DIM);
  localparam int SW = 31 + $clog2(MAX_DIM);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADDW = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_FMT  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]                    state;
  logic [2:0]                    state_next;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 k;
  logic [SW-1:0]                 sum;
  logic                          ovf;
  logic [2*l2n_pkg::VAL_W-1:0]   sq_in;
  logic                          sq_v;
  logic                          in_acc;
  logic                          out_acc;
  logic                          room;
  logic                          zero;
  logic [l2n_pkg::VAL_W-1:0]     rdata;
  logic [l2n_pkg::VAL_W-1:0]     mag_in;
  logic [l2n_pkg::VAL_W-1:0]     mag_rd;
  logic [l2n_pkg::VAL_W-1:0]     q;
  logic                          start;
  l2n_pkg::root_stat_t           root_stat;

  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = (state == S_OUT);
  assign out_acc   = out_valid & ~out_stall;
  assign room      = (count < CW'(MAX_DIM));
  assign zero      = (sum == '0);
  assign mag_in    = l2n_pkg::magnitude(value);
  assign mag_rd    = l2n_pkg::magnitude(rdata);
  assign start     = (state == S_LOAD) && !zero;

  l2n_store #(
    .DEPTH  (MAX_DIM),
    .DATA_W (l2n_pkg::VAL_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_acc & room),
    .wr_addr (count[AW-1:0]),
    .wr_data (value),
    .rd_addr (k[AW-1:0]),
    .rd_data (rdata)
  );

  l2n_root_unit #(
    .SUM_W (SW)
  ) u_root (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mag   (mag_rd),
    .sum   (sum),
    .q     (q),
    .stat  (root_stat)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc && last) begin
          state_next = S_ADDW;
        end
      end
      S_ADDW: state_next = S_READ;
      S_READ: state_next = S_LOAD;
      S_LOAD: state_next = zero ? S_FMT : S_WAIT;
      S_WAIT: begin
        if (root_stat.done) begin
          state_next = S_FMT;
        end
      end
      S_FMT:  state_next = S_OUT;
      S_OUT: begin
        if (out_acc) begin
          state_next = end_of_vector ? S_IDLE : S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      k     <= '0;
      sum   <= '0;
      ovf   <= 1'b0;
      sq_v  <= 1'b0;
    end else begin
      state <= state_next;
      sq_v  <= in_acc & room;
      if (in_acc) begin
        if (room) begin
          count <= count + CW'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      // The square of the previous beat, registered in sq_in, is folded into sum in the cycle after it was taken.
      if (out_acc && end_of_vector) begin
        count <= '0;
        k     <= '0;
        sum   <= '0;
        ovf   <= 1'b0;
      end else begin
        if (sq_v) begin
          sum <= sum + SW'(sq_in);
        end
        if (out_acc) begin
          k <= k + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sq_in <= mag_in * mag_in;
    end
    if (state == S_FMT) begin
      norm_value    <= zero ? '0 : l2n_pkg::format_q(q, rdata[l2n_pkg::VAL_W-1]);
      end_of_vector <= ((k + CW'(1)) == count);
      status        <= zero ? l2n_pkg::ST_ZERO : (ovf ? l2n_pkg::ST_DROP : l2n_pkg::ST_OK);
    end
  end

`ifndef NO_ASSERTIONS
  a_last_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_acc && last) |=> in_stall)
    else $error("input taken straight after the final element of a vector");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    root_stat.done |-> (state == S_WAIT))
    else $error("root unit finished outside the wait state");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    start |-> !root_stat.busy)
    else $error("root unit started while still busy");

  a_clear_after_vector: assert property (@(posedge clk) disable iff (rst)
    (out_acc && end_of_vector) |=> (count == '0 && sum == '0 && !ovf))
    else $error("accumulation state not cleared after the final result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_DIM))
    else $error("element count beyond capacity");
`endif

endmodule

### test/testbench.sv
// Testbench for vector_l2_normalizer_core: directed and random vectors, every result checked against
// a built-in predictor of the L2 normalisation or a typed-in result. Depends on hdl/l2n_pkg.sv and the core.
`timescale 1ns / 1ps

module testbench;

  localparam int          VAL_W       = l2n_pkg::VAL_W;
  localparam int          STATUS_W    = l2n_pkg::STATUS_W;
  localparam int          DEPTH       = l2n_pkg::MAX_DIM_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          IDLE_PCT    = 27;
  localparam int          HOLD_CYCLES = 300;
  localparam int          N_DIRECTED  = 22;
  localparam int          ITEM_TARGET = 130;

  typedef struct {
    logic [VAL_W-1:0]    norm;
    logic                eov;
    logic [STATUS_W-1:0] st;
  } norm_result_t;

  typedef struct packed {
    logic [VAL_W-1:0]    value;
    logic                fin;
    logic                typed;
    logic [VAL_W-1:0]    norm;
    logic [STATUS_W-1:0] st;
  } stim_row_t;

  typedef enum int {VK_WIDE, VK_TINY, VK_PEAK, VK_ZERO, VK_SHIFTED} vec_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [VAL_W-1:0] value = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [VAL_W-1:0] norm_value;
  logic end_of_vector;
  logic [STATUS_W-1:0] status;

  logic tx_gaps = 1'b1;
  logic rx_gaps = 1'b1;
  logic hold_req = 1'b0;
  bit   hold_taken = 1'b0;

  // Predictor state: elements of the vector being collected and their sum of squares.
  logic [VAL_W-1:0] held_elems [DEPTH];
  logic [63:0]      sum_sq = '0;
  int               held_count = 0;
  bit               over_cap = 1'b0;

  norm_result_t expected_q[$];
  int errors = 0;
  int results_checked = 0;
  int beats_sent = 0;
  int vectors_sent = 0;
  int unsigned cycle_count = 0;

  // Single-element vectors, among them a zero one and the extremes, carry their result typed in.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{16'h7FFF, 1'b1, 1'b1, 16'h7FFF, l2n_pkg::ST_OK},
    '{16'h8000, 1'b1, 1'b1, 16'h8001, l2n_pkg::ST_OK},
    '{16'h0000, 1'b1, 1'b1, 16'h0000, l2n_pkg::ST_ZERO},
    '{16'h0001, 1'b1, 1'b1, 16'h7FFF, l2n_pkg::ST_OK},
    '{16'hFFFF, 1'b1, 1'b1, 16'h8001, l2n_pkg::ST_OK},
    '{16'h0003, 1'b0, 1'b0, 16'h0000, l2n_pkg::ST_OK},
    '{16'h0004, 1'b1, 1'b0, 16'h0000, l2n_pkg::ST_OK},
    '{16'hFFFD, 1'b0, 1'b0, 16'h0000, l2n_pkg::ST_OK},
    '{16'hFFFC, 1'b1, 1'b0, 16'h0000, l2n_pkg::ST_OK},
    '{16'h0000, 1'b0, 1'b0, 16'h0000, l2n_pkg::ST_OK},
    '{16'h0000, 1'b0, 1'b0, 16'h0000, l2n_pkg::ST_OK},
    '{16'h0000, 1'b1, 1'b0, 16'h0000, l2n_pkg::ST_OK},
    '{16'h7FFF, 1'b0, 1'b0, 16'h0000, l2n_pkg::ST_OK},
    '{16'h8000, 1'b1, 1'b0, 16'h0000, l2n_pkg::ST_OK},
    '{16'h0000, 1'b0, 1'b0, 16'h0000, l2n_pkg::ST_OK},
    '{16'h0005, 1'b1, 1'b0, 16'h0000, l2n_pkg::ST_OK},
    '{16'h0001, 1'b0, 1'b0, 16'h0000, l2n_pkg::ST_OK},
    '{16'hFFFF, 1'b0, 1'b0, 16'h0000, l2n_pkg::ST_OK},
    '{16'h7FFF, 1'b0, 1'b0, 16'h0000, l2n_pkg::ST_OK},
    '{16'h4000, 1'b1, 1'b0, 16'h0000, l2n_pkg::ST_OK},
    '{16'h5555, 1'b0, 1'b0, 16'h0000, l2n_pkg::ST_OK},
    '{16'hAAAA, 1'b1, 1'b0, 16'h0000, l2n_pkg::ST_OK}
  };

  vector_l2_normalizer_core uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .norm_value   (norm_value),
    .end_of_vector(end_of_vector),
    .status       (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[vector_l2_normalizer_core] ERROR");
      $finish;
    end
  end

  // Largest q with q*q*sum <= x*x*2^30, saturated and given the sign of x.
  function automatic logic [VAL_W-1:0] q15_scaled(input logic [VAL_W-1:0] x,
                                                  input logic [63:0]      sum);
    logic [63:0] mag, ratio, root, trial;
    int b;
    mag   = 64'(l2n_pkg::magnitude(x));
    ratio = ((mag * mag) << l2n_pkg::FRAC_SHIFT) / sum;
    root  = '0;
    for (b = 15; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= ratio) root = trial;
    end
    if (root > 64'd32767) root = 64'd32767;
    return x[VAL_W-1] ? VAL_W'(-root) : VAL_W'(root);
  endfunction

  function automatic void predict_beat(input logic [VAL_W-1:0] x, input logic fin);
    logic [63:0] mag;
    logic [STATUS_W-1:0] st;
    norm_result_t r;
    int k;
    if (held_count < DEPTH) begin
      mag = 64'(l2n_pkg::magnitude(x));
      held_elems[held_count] = x;
      sum_sq += mag * mag;
      held_count++;
    end else begin
      over_cap = 1'b1;
    end
    if (fin) begin
      // A zero vector reports as such even when elements were dropped.
      st = (sum_sq == 0) ? l2n_pkg::ST_ZERO : (over_cap ? l2n_pkg::ST_DROP : l2n_pkg::ST_OK);
      for (k = 0; k < held_count; k++) begin
        r.norm = (sum_sq == 0) ? '0 : q15_scaled(held_elems[k], sum_sq);
        r.eov  = (k == held_count - 1);
        r.st   = st;
        expected_q.push_back(r);
      end
      sum_sq     = '0;
      held_count = 0;
      over_cap   = 1'b0;
    end
  endfunction

  function automatic logic [VAL_W-1:0] pick_element(input vec_kind_t kind, input int pos);
    case (kind)
      VK_WIDE: return VAL_W'($urandom_range(0, 65535));
      VK_TINY: return VAL_W'($urandom_range(0, 8)) - VAL_W'(4);
      VK_PEAK: begin
        if (pos != 0) return VAL_W'($urandom_range(0, 6)) - VAL_W'(3);
        case ($urandom_range(0, 3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h8001;
          default: return VAL_W'($urandom_range(0, 65535));
        endcase
      end
      VK_ZERO: return '0;
      default: return VAL_W'($signed(VAL_W'($urandom)) >>> $urandom_range(0, 15));
    endcase
  endfunction

  task automatic send_beat(input logic [VAL_W-1:0] x, input logic fin);
    while (tx_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= x;
    last     <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat(x, fin);
    beats_sent++;
    if (fin) vectors_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off so the block backs up into its input.
  initial begin : receiver
    int n;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= rx_gaps && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    norm_result_t e;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      results_checked++;
      if (expected_q.size() == 0) begin
        $error("norm_value: no result expected, got %h (end_of_vector %b, status %0d)",
               norm_value, end_of_vector, status);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (norm_value !== e.norm) begin
          $error("norm_value: expected %h, got %h", e.norm, norm_value);
          errors++;
        end
        if (end_of_vector !== e.eov) begin
          $error("end_of_vector: expected %b, got %b", e.eov, end_of_vector);
          errors++;
        end
        if (status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, status);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    int i, vec, len;
    vec_kind_t kind;
    norm_result_t typed_r;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < N_DIRECTED; i++) begin
      send_beat(directed_rows[i].value, directed_rows[i].fin);
      if (directed_rows[i].typed) begin
        void'(expected_q.pop_back());
        typed_r.norm = directed_rows[i].norm;
        typed_r.eov  = 1'b1;
        typed_r.st   = directed_rows[i].st;
        expected_q.push_back(typed_r);
      end
    end

    for (vec = 0; vec < 12 || beats_sent < ITEM_TARGET; vec++) begin
      if (vec == 4) hold_req <= 1'b1;
      if (vec == 6) drain_results();
      if (vec == 7) begin
        tx_gaps <= 1'b0;
        rx_gaps <= 1'b0;
      end
      if (vec == 11) begin
        tx_gaps <= 1'b1;
        rx_gaps <= 1'b1;
      end
      kind = vec_kind_t'($urandom_range(0, 4));
      len  = (kind == VK_WIDE) ? $urandom_range(1, 12) : $urandom_range(1, 6);
      // One vector runs a beat or two past capacity, so the buffer fills and drops.
      if (vec == 2) begin
        kind = VK_WIDE;
        len  = $urandom_range(DEPTH + 1, DEPTH + 2);
      end
      for (i = 0; i < len; i++) send_beat(pick_element(kind, i), i == len - 1);
    end

    drain_results();
    repeat (60) @(posedge clk);
    $display("Sent %0d beats in %0d vectors; %0d results checked.", beats_sent, vectors_sent,
             results_checked);
    $display("Covered extremes, zero vectors, a full buffer with dropped beats and back-pressure.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("[vector_l2_normalizer_core] OK");
    end else begin
      $display("[vector_l2_normalizer_core] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hdl/l2n_pkg.sv
hdl/l2n_store.sv
hdl/l2n_root_unit.sv
hdl/vector_l2_normalizer_core.sv
test/testbench.sv
